### src/bitmap_page_range_allocator_assert.svh
// Assertion macros shared by the page range allocator modules
`ifndef BITMAP_PAGE_RANGE_ALLOCATOR_ASSERT_SVH
`define BITMAP_PAGE_RANGE_ALLOCATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BPRA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BPRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/bpra_pkg.sv
// Shared constants and types of the bitmap page range allocator
package bpra_pkg;

    localparam int NUM_PAGES  = 1024;
    localparam int PAGE_SHIFT = 12;
    localparam int ADDR_W     = 32;
    localparam int CNT_W      = 11;
    localparam int PAGE_W     = $clog2(NUM_PAGES);
    localparam int PTR_W      = PAGE_W + 1;
    localparam int WORD_W     = 32;
    localparam int WBIT_W     = $clog2(WORD_W);
    localparam int NUM_WORDS  = NUM_PAGES / WORD_W;
    localparam int WIDX_W     = $clog2(NUM_WORDS);
    localparam int CHUNK      = 8;
    localparam int CHUNK_W    = $clog2(CHUNK);
    localparam int BSEL_W     = WBIT_W - CHUNK_W;
    localparam int GRP_W      = PAGE_W - CHUNK_W;
    localparam int APB_AW     = 2;
    localparam int APB_DW     = 32;

    localparam logic [APB_AW-1:0] REG_HEAP_BASE = '0;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [CNT_W-1:0]  run_len;
        logic [ADDR_W-1:0] free_addr;
    } t_req;

    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] run_addr;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic scan_hi;
        logic scan_lo;
        logic scan_step;
        logic mark_start;
        logic free_start;
        logic run_step;
    } t_ctl;

    typedef struct packed {
        logic is_free;
        logic bad_count;
        logic found;
        logic scan_end;
        logic run_done;
    } t_sts;

endpackage

### src/bpra_ctrl.sv
// Sequencer for allocate and free commands of the page range allocator
module bpra_ctrl import bpra_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_ctl o_ctl,
    output logic o_busy,
    output logic o_done
);

    `include "bitmap_page_range_allocator_assert.svh"

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_SCAN1 = 3'd2;
    localparam logic [2:0] S_SCAN2 = 3'd3;
    localparam logic [2:0] S_RUN   = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                if (i_sts.is_free) begin
                    o_ctl.free_start = 1'b1;
                    n_state          = S_RUN;
                end else if (i_sts.bad_count) begin
                    n_state = S_RESP;
                end else begin
                    o_ctl.scan_hi = 1'b1;
                    n_state       = S_SCAN1;
                end
            end
            S_SCAN1: begin
                if (i_sts.found) begin
                    o_ctl.mark_start = 1'b1;
                    n_state          = S_RUN;
                end else if (i_sts.scan_end) begin
                    o_ctl.scan_lo = 1'b1;
                    n_state       = S_SCAN2;
                end else begin
                    o_ctl.scan_step = 1'b1;
                end
            end
            S_SCAN2: begin
                if (i_sts.found) begin
                    o_ctl.mark_start = 1'b1;
                    n_state          = S_RUN;
                end else if (i_sts.scan_end) begin
                    n_state = S_RESP;
                end else begin
                    o_ctl.scan_step = 1'b1;
                end
            end
            S_RUN: begin
                if (i_sts.run_done) begin
                    n_state = S_RESP;
                end else begin
                    o_ctl.run_step = 1'b1;
                end
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_RESP);

    `BPRA_ASSERT_NEXT(a_accept_prep, r_state == S_IDLE && i_start, r_state == S_PREP,
        "accepted command did not enter prep")
    `BPRA_ASSERT_NEXT(a_resp_idle, r_state == S_RESP, r_state == S_IDLE,
        "result beat not followed by idle")
    `BPRA_ASSERT_NOW(a_one_action, 1'b1, $onehot0(o_ctl),
        "more than one datapath command at once")

endmodule

### src/bpra_dp.sv
// Page bitmap, search hint, scan and mark/clear datapath of the allocator
module bpra_dp import bpra_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_req              i_req,
    input  logic [ADDR_W-1:0] i_heap_base,
    input  t_ctl              i_ctl,
    output t_sts              o_sts,
    output t_rsp              o_rsp
);

    `include "bitmap_page_range_allocator_assert.svh"

    logic [WORD_W-1:0] r_map [NUM_WORDS];
    logic [PAGE_W-1:0] r_hint;
    logic              r_cmd;
    logic [CNT_W-1:0]  r_cnt;
    logic [ADDR_W-1:0] r_faddr;
    logic [PTR_W-1:0]  r_ptr;
    logic [PTR_W-1:0]  r_hi;
    logic [CNT_W-1:0]  r_run;
    logic              r_found;
    logic [PAGE_W-1:0] r_first;
    logic [PTR_W-1:0]  r_mptr;
    logic [CNT_W-1:0]  r_rem;
    logic              r_set;
    logic              r_ok;
    logic [ADDR_W-1:0] r_addr;

    logic [WIDX_W-1:0] rd_idx;
    logic [WORD_W-1:0] rd_word;
    logic [GRP_W-1:0]  grp;
    logic [BSEL_W-1:0] bsel;
    logic [CHUNK-1:0]  chunk;
    logic [CNT_W-1:0]  n_run;
    logic              n_found;
    logic [PAGE_W-1:0] n_first;
    logic [PTR_W-1:0]  n_ptr;

    logic [WBIT_W-1:0] off;
    logic [WBIT_W:0]   room;
    logic [WBIT_W:0]   step_n;
    logic [WBIT_W:0]   lim;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] n_word;

    logic [ADDR_W-1:0]            fdiff;
    logic [ADDR_W-PAGE_SHIFT-1:0] fpage;
    logic                         fin_map;
    logic [PTR_W-1:0]             mend;

    assign grp     = r_ptr[PAGE_W-1:CHUNK_W];
    assign bsel    = r_ptr[WBIT_W-1:CHUNK_W];
    assign rd_idx  = i_ctl.run_step ? r_mptr[PAGE_W-1:WBIT_W] : r_ptr[PAGE_W-1:WBIT_W];
    assign rd_word = r_map[rd_idx];
    assign chunk   = rd_word[bsel*CHUNK +: CHUNK];
    assign n_ptr   = PTR_W'({grp, CHUNK_W'(0)}) + PTR_W'(CHUNK);

    // one aligned group of pages per step, skip pages outside [ptr, hi)
    always_comb begin
        logic [PTR_W-1:0] pos;
        n_run   = r_run;
        n_found = 1'b0;
        n_first = r_first;
        for (int k = 0; k < CHUNK; k++) begin
            pos = PTR_W'({grp, CHUNK_W'(k)});
            if (pos >= r_ptr && pos < r_hi && !n_found) begin
                if (chunk[k]) begin
                    n_run = '0;
                end else begin
                    n_run = n_run + CNT_W'(1);
                    if (n_run >= r_cnt) begin
                        n_found = 1'b1;
                        n_first = PAGE_W'(pos + PTR_W'(1) - PTR_W'(r_cnt));
                    end
                end
            end
        end
    end

    // mark or clear up to one word of the run per step
    assign off    = r_mptr[WBIT_W-1:0];
    assign room   = (WBIT_W+1)'(WORD_W) - (WBIT_W+1)'(off);
    assign step_n = (r_rem < CNT_W'(room)) ? (WBIT_W+1)'(r_rem) : room;
    assign lim    = (WBIT_W+1)'(off) + step_n;

    always_comb begin
        for (int j = 0; j < WORD_W; j++) begin
            mask[j] = ((WBIT_W+1)'(j) >= (WBIT_W+1)'(off)) && ((WBIT_W+1)'(j) < lim);
        end
    end

    assign n_word = r_set ? (rd_word | mask) : (rd_word & ~mask);

    assign fdiff   = r_faddr - i_heap_base;
    assign fpage   = fdiff[ADDR_W-1:PAGE_SHIFT];
    assign fin_map = (ADDR_W'(fpage) < ADDR_W'(NUM_PAGES));
    assign mend    = PTR_W'(r_first) + PTR_W'(r_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < NUM_WORDS; w++) begin
                r_map[w] <= '0;
            end
            r_hint  <= '0;
            r_cmd   <= CMD_ALLOC;
            r_cnt   <= '0;
            r_ptr   <= '0;
            r_hi    <= '0;
            r_run   <= '0;
            r_found <= 1'b0;
            r_first <= '0;
            r_mptr  <= '0;
            r_rem   <= '0;
            r_set   <= 1'b0;
            r_ok    <= 1'b0;
            r_addr  <= '0;
        end else begin
            if (i_ctl.load) begin
                r_cmd   <= i_req.cmd;
                r_cnt   <= i_req.run_len;
                r_faddr <= i_req.free_addr;
                r_run   <= '0;
                r_found <= 1'b0;
                r_ok    <= 1'b0;
                r_addr  <= '0;
            end
            if (i_ctl.scan_hi) begin
                r_ptr   <= PTR_W'(r_hint);
                r_hi    <= PTR_W'(NUM_PAGES);
                r_run   <= '0;
                r_found <= 1'b0;
            end
            if (i_ctl.scan_lo) begin
                r_ptr   <= '0;
                r_hi    <= PTR_W'(r_hint);
                r_run   <= '0;
                r_found <= 1'b0;
            end
            if (i_ctl.scan_step) begin
                r_ptr   <= n_ptr;
                r_run   <= n_run;
                r_found <= n_found;
                r_first <= n_first;
            end
            if (i_ctl.mark_start) begin
                r_mptr <= PTR_W'(r_first);
                r_rem  <= r_cnt;
                r_set  <= 1'b1;
                r_hint <= (mend < PTR_W'(NUM_PAGES)) ? mend[PAGE_W-1:0] : '0;
                r_ok   <= 1'b1;
                r_addr <= i_heap_base + (ADDR_W'(r_first) << PAGE_SHIFT);
            end
            if (i_ctl.free_start) begin
                r_mptr <= fin_map ? PTR_W'(fpage) : '0;
                r_rem  <= fin_map ? r_cnt : '0;
                r_set  <= 1'b0;
                if (ADDR_W'(fpage) < ADDR_W'(r_hint)) begin
                    r_hint <= PAGE_W'(fpage);
                end
                r_ok   <= 1'b1;
                r_addr <= '0;
            end
            if (i_ctl.run_step) begin
                r_map[rd_idx] <= n_word;
                r_mptr        <= r_mptr + PTR_W'(step_n);
                r_rem         <= r_rem - CNT_W'(step_n);
            end
        end
    end

    assign o_sts.is_free   = (r_cmd == CMD_FREE);
    assign o_sts.bad_count = (r_cnt == '0) || (32'(r_cnt) > 32'(NUM_PAGES));
    assign o_sts.found     = r_found;
    assign o_sts.scan_end  = (r_ptr >= r_hi);
    assign o_sts.run_done  = (r_rem == '0) || (r_mptr >= PTR_W'(NUM_PAGES));

    assign o_rsp.ok       = r_ok;
    assign o_rsp.run_addr = r_addr;

    `BPRA_ASSERT_NEXT(a_mark_ok, i_ctl.mark_start, r_ok && r_set,
        "run marked without success flag")
    `BPRA_ASSERT_NOW(a_run_bound, 1'b1, r_run <= r_cnt,
        "free run counter passed requested count")
    `BPRA_ASSERT_NEXT(a_rem_drops, i_ctl.run_step && r_rem != '0, r_rem < $past(r_rem),
        "run step made no progress")

endmodule

### src/bitmap_page_range_allocator.sv
// Top level of the bitmap page range allocator with its configuration port
//
//  channel   handshake              payload
//  command   start / busy           i_req  (cmd, run_len, free_addr)
//  result    o_done strobe          o_rsp  (ok, run_addr)
//  config    psel/penable/pready    paddr, pwdata, pwrite, prdata (heap_base)
//
//  Allocate: a rejected count skips the scan; otherwise a scan of 8 pages
//  per cycle from the hint to the end and from 0 to the hint, then marking
//  of up to 32 pages per cycle.
//  Free: clears the run one bitmap word per step, up to 32 words touched.
//  Synchronous active-low reset clears the bitmap and the hint at once.
//  busy stays high through the result beat; results cannot be stalled.
module bitmap_page_range_allocator import bpra_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  t_req              i_req,
    output logic              o_done,
    output t_rsp              o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [ADDR_W-1:0] r_heap_base;
    logic              cfg_wr;
    t_ctl              ctl;
    t_sts              sts;

    // decode the heap_base register
    assign cfg_wr = psel && penable && pwrite && (paddr == REG_HEAP_BASE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base <= '0;
        end else if (cfg_wr) begin
            r_heap_base <= pwdata;
        end
    end

    assign prdata = r_heap_base;
    assign pready = 1'b1;

    bpra_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    bpra_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_heap_base (r_heap_base),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .o_rsp       (o_rsp)
    );

endmodule

### dv/bitmap_page_range_allocator_test.sv
// Self-checking testbench for the bitmap page range allocator
`timescale 1ns / 100ps

module bitmap_page_range_allocator_test;
    import bpra_pkg::*;

    localparam int RAND_PHASES    = 8;
    localparam int RAND_PER_PHASE = 204;
    localparam int TAIL_CYCLES    = 200;

    logic              i_clk;
    logic              i_rst_n   = 1'b0;
    logic              start     = 1'b0;
    logic              busy;
    t_req              req_beat  = '0;
    logic              o_done;
    t_rsp              o_rsp;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [APB_AW-1:0] paddr     = '0;
    logic [APB_DW-1:0] pwdata    = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    t_req              beat_q[$];
    t_rsp              grant_q[$];
    int                burst_left = 0;
    int                gap_left   = 0;
    int                errors     = 0;

    bit [NUM_PAGES-1:0] page_map         = '0;
    int unsigned        next_fit_page    = 0;
    logic [ADDR_W-1:0]  heap_base_shadow = '0;

    bitmap_page_range_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (req_beat),
        .o_done  (o_done),
        .o_rsp   (o_rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic flag_error(string what);
        errors++;
        $display("%0t ns mismatch: %s", $time, what);
    endtask

    function automatic bit find_free_run(int unsigned lo, int unsigned hi, int unsigned count,
                                         output int unsigned first);
        int unsigned run;
        run   = 0;
        first = 0;
        for (int unsigned p = lo; p < hi; p++) begin
            if (page_map[p]) begin
                run = 0;
            end else begin
                run++;
                if (run >= count) begin
                    first = p + 1 - count;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic t_rsp model_command(t_req req);
        t_rsp              rsp;
        int unsigned       cnt;
        int unsigned       first;
        int unsigned       fpage;
        bit                found;
        logic [ADDR_W-1:0] offset;
        rsp   = '0;
        cnt   = req.run_len;
        first = 0;
        found = 1'b0;
        if (req.cmd == CMD_ALLOC) begin
            if (cnt != 0 && cnt <= NUM_PAGES) begin
                found = find_free_run(next_fit_page, NUM_PAGES, cnt, first);
                if (!found) begin
                    found = find_free_run(0, next_fit_page, cnt, first);
                end
            end
            if (found) begin
                for (int unsigned p = first; p < first + cnt; p++) begin
                    page_map[p] = 1'b1;
                end
                next_fit_page = (first + cnt < NUM_PAGES) ? first + cnt : 0;
                rsp.ok        = 1'b1;
                rsp.run_addr  = heap_base_shadow + (ADDR_W'(first) << PAGE_SHIFT);
            end
        end else begin
            offset = req.free_addr - heap_base_shadow;
            fpage  = offset >> PAGE_SHIFT;
            for (int unsigned i = 0; i < cnt; i++) begin
                if (fpage + i < NUM_PAGES) begin
                    page_map[fpage + i] = 1'b0;
                end
            end
            if (fpage < next_fit_page) begin
                next_fit_page = fpage;
            end
            rsp.ok = 1'b1;
        end
        return rsp;
    endfunction

    function automatic t_req mk_beat(logic cmd, int unsigned cnt, logic [ADDR_W-1:0] addr);
        t_req b;
        b.cmd       = cmd;
        b.run_len   = CNT_W'(cnt);
        b.free_addr = addr;
        return b;
    endfunction

    function automatic t_req rand_beat(logic [ADDR_W-1:0] base);
        t_req        b;
        int unsigned sel;
        int unsigned size_sel;
        int unsigned page;
        sel      = $urandom_range(0, 99);
        size_sel = $urandom_range(0, 99);
        page     = $urandom_range(0, NUM_PAGES - 1);
        b        = mk_beat(CMD_ALLOC, 1, $urandom());
        if (sel < 45) begin
            if (size_sel < 85) begin
                b.run_len = CNT_W'($urandom_range(1, 16));
            end else if (size_sel < 97) begin
                b.run_len = CNT_W'($urandom_range(17, 128));
            end else begin
                b.run_len = CNT_W'($urandom_range(129, NUM_PAGES));
            end
        end else if (sel < 85) begin
            b.cmd       = CMD_FREE;
            b.run_len   = CNT_W'($urandom_range(1, 64));
            b.free_addr = base + (ADDR_W'(page) << PAGE_SHIFT);
            if ($urandom_range(0, 3) == 0) begin
                b.free_addr = b.free_addr + ($urandom() & 32'h0000_0FFF);
            end
        end else if (sel < 88) begin
            b = mk_beat(CMD_FREE, NUM_PAGES, base);
        end else begin
            b.cmd       = 1'($urandom_range(0, 1));
            b.run_len   = CNT_W'($urandom());
            b.free_addr = $urandom();
        end
        return b;
    endfunction

    task automatic cfg_write(logic [APB_DW-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_HEAP_BASE;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        heap_base_shadow = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== value) begin
            flag_error($sformatf("heap_base read %h, wrote %h", prdata, value));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_idle();
        while (beat_q.size() != 0 || start || busy || grant_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                grant_q.push_back(model_command(req_beat));
                void'(beat_q.pop_front());
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
                end
            end
            if (!start || !busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (beat_q.size() != 0) begin
                    start    <= 1'b1;
                    req_beat <= beat_q[0];
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_done) begin
            if (grant_q.size() == 0) begin
                flag_error($sformatf("result ok=%b addr=%h with none pending",
                                     o_rsp.ok, o_rsp.run_addr));
            end else begin
                want = grant_q.pop_front();
                if (o_rsp.ok !== want.ok) begin
                    flag_error($sformatf("ok %b, want %b", o_rsp.ok, want.ok));
                end
                if (o_rsp.run_addr !== want.run_addr) begin
                    flag_error($sformatf("run_addr %h, want %h", o_rsp.run_addr, want.run_addr));
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("bitmap_page_range_allocator_test: errors");
        $finish;
    end

    initial begin
        logic [ADDR_W-1:0] bases [RAND_PHASES];
        bases = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom() & 32'hFFFF_F000, $urandom(),
                  32'h8000_0000, $urandom() & 32'hFFFF_F000, 32'hFFFF_F000,
                  $urandom() & 32'hFFFF_F000};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        beat_q.push_back(mk_beat(CMD_ALLOC, 0, 32'h0000_0000));
        beat_q.push_back(mk_beat(CMD_ALLOC, NUM_PAGES + 1, 32'hFFFF_FFFF));
        beat_q.push_back(mk_beat(CMD_ALLOC, 2047, 32'h0000_0000));
        beat_q.push_back(mk_beat(CMD_ALLOC, 1, 32'h0000_0000));
        beat_q.push_back(mk_beat(CMD_ALLOC, NUM_PAGES - 1, 32'h0000_0000));
        beat_q.push_back(mk_beat(CMD_ALLOC, 1, 32'h0000_0000));
        beat_q.push_back(mk_beat(CMD_FREE, NUM_PAGES, 32'h0000_0000));
        beat_q.push_back(mk_beat(CMD_ALLOC, NUM_PAGES, 32'h0000_0000));
        beat_q.push_back(mk_beat(CMD_FREE, 1, 32'h0000_2000));
        beat_q.push_back(mk_beat(CMD_FREE, 10, 32'h0000_AFFF));
        beat_q.push_back(mk_beat(CMD_ALLOC, 5, 32'h0000_0000));
        beat_q.push_back(mk_beat(CMD_FREE, 2, 32'h0000_3000));
        beat_q.push_back(mk_beat(CMD_ALLOC, 3, 32'h0000_0000));
        beat_q.push_back(mk_beat(CMD_FREE, 2047, 32'hFFFF_F000));
        beat_q.push_back(mk_beat(CMD_FREE, 0, 32'h0010_0ABC));
        beat_q.push_back(mk_beat(CMD_FREE, 0, 32'h0000_5000));
        beat_q.push_back(mk_beat(CMD_FREE, 2047, 32'h0000_0000));
        beat_q.push_back(mk_beat(CMD_FREE, 4, 32'h0000_0000));
        wait_idle();

        cfg_write(32'hFFFF_F000);
        beat_q.push_back(mk_beat(CMD_ALLOC, 2, 32'h1234_5678));
        beat_q.push_back(mk_beat(CMD_ALLOC, 1, 32'h0000_0000));
        beat_q.push_back(mk_beat(CMD_FREE, 1, 32'h0000_0000));
        beat_q.push_back(mk_beat(CMD_FREE, 1, 32'hFFFF_E000));
        beat_q.push_back(mk_beat(CMD_FREE, NUM_PAGES, 32'hFFFF_F000));
        wait_idle();

        for (int k = 0; k < RAND_PHASES; k++) begin
            cfg_write(bases[k]);
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                beat_q.push_back(rand_beat(bases[k]));
            end
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && grant_q.size() == 0) begin
            $display("bitmap_page_range_allocator_test: clean");
        end else begin
            $display("bitmap_page_range_allocator_test: errors");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/bpra_pkg.sv
src/bpra_ctrl.sv
src/bpra_dp.sv
src/bitmap_page_range_allocator.sv
dv/bitmap_page_range_allocator_test.sv
